### hdl/irpwc_pkg.sv
// Shared types, register codes and reset values of the IR pulse-width capture block.
`default_nettype none
package irpwc_pkg;

  localparam int unsigned SampleW    = 8;
  localparam int unsigned ThreshW    = 8;
  localparam int unsigned TimeoutW   = 10;
  localparam int unsigned DurW       = 11;
  localparam int unsigned IndexW     = 10;
  localparam int unsigned CountW     = 11;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 11;
  localparam int unsigned QueueDepth = 2;

  localparam logic signed [ThreshW-1:0] ThresholdReset = 8'sd25;
  localparam logic [TimeoutW-1:0]       TimeoutReset   = 10'd255;
  localparam logic [DurW-1:0]           TailReset      = 11'd100;
  localparam logic [IndexW-1:0]         MaxRunsReset   = 10'd250;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [DurW-1:0]   DurMax   = '1;

  typedef enum logic [CfgIndexW-1:0] {
    REG_LEVEL_THRESHOLD = 2'd0,
    REG_TIMEOUT_LIMIT   = 2'd1,
    REG_TAIL_VALUE      = 2'd2,
    REG_MAX_RUNS        = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [ThreshW-1:0] level_threshold;
    logic [TimeoutW-1:0]       timeout_limit;
    logic [DurW-1:0]           tail_value;
    logic [IndexW-1:0]         max_runs;
  } cfg_t;

endpackage
`default_nettype wire

### hdl/irpwc_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
`default_nettype none
interface irpwc_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_byte;
  modport source (output valid, output sample_byte, input ready);
  modport sink (input valid, input sample_byte, output ready);
endinterface

interface irpwc_result_if;
  logic        valid;
  logic        ready;
  logic [10:0] duration;
  logic        run_level;
  logic [9:0]  run_index;
  logic        frame_end;
  logic        overflow;
  modport source (output valid, output duration, output run_level, output run_index,
                  output frame_end, output overflow, input ready);
  modport sink (input valid, input duration, input run_level, input run_index,
                input frame_end, input overflow, output ready);
endinterface

interface irpwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/irpwc_front.sv
// Front end: register file and sample level classifier feeding the level queue.
`default_nettype none
module irpwc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  irpwc_sample_if.sink          sample_in,
  irpwc_cfg_if.sink             cfg,
  input  wire logic             full,
  output logic                  push,
  output logic                  push_level,
  output irpwc_pkg::cfg_t       regs
);
  import irpwc_pkg::*;

  logic signed [SampleW-1:0] centered;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.level_threshold <= ThresholdReset;
      regs.timeout_limit   <= TimeoutReset;
      regs.tail_value      <= TailReset;
      regs.max_runs        <= MaxRunsReset;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_LEVEL_THRESHOLD: regs.level_threshold <= signed'(cfg.data[ThreshW-1:0]);
        REG_TIMEOUT_LIMIT:   regs.timeout_limit   <= cfg.data[TimeoutW-1:0];
        REG_TAIL_VALUE:      regs.tail_value      <= cfg.data[DurW-1:0];
        REG_MAX_RUNS:        regs.max_runs        <= cfg.data[IndexW-1:0];
        default: ;
      endcase
    end
  end

  // offset binary to two's complement: flip the sign bit
  assign centered        = signed'({~sample_in.sample_byte[SampleW-1],
                                    sample_in.sample_byte[SampleW-2:0]});
  assign push_level      = (centered > regs.level_threshold);
  assign sample_in.ready = !full;
  assign push            = sample_in.valid && !full;

endmodule
`default_nettype wire

### hdl/irpwc_queue.sv
// Small FIFO of classified levels between front and back.
`default_nettype none
module irpwc_queue #(
  parameter int unsigned Depth = irpwc_pkg::QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire logic push_level,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output logic      head_level
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Depth-1:0] mem;
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  fill;

  assign full       = (fill == CntFull);
  assign not_empty  = (fill != '0);
  assign head_level = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/irpwc_back.sv
// Back end: run and quiet counters, frame control, rescale and result register.
`default_nettype none
module irpwc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire irpwc_pkg::cfg_t  regs,
  input  wire logic             q_not_empty,
  input  wire logic             q_level,
  output logic                  pop,
  irpwc_result_if.source        result_out
);
  import irpwc_pkg::*;

  logic              capturing, capturing_next;
  logic              previous_level, previous_level_next;
  logic [CountW-1:0] run_count, run_count_next;
  logic [CountW-1:0] quiet_count, quiet_count_next;
  logic [IndexW-1:0] items_in_frame, items_in_frame_next;
  logic              halted, halted_next;

  logic              emit;
  logic [DurW-1:0]   emit_dur;
  logic              emit_level;
  logic [IndexW-1:0] emit_index;
  logic              emit_end;
  logic              emit_ovf;

  logic              out_valid;

  // floor((50n+24)/48) = floor(floor((25n+12)/8)/3), divide by 3 via reciprocal
  function automatic logic [DurW-1:0] rescale(input logic [CountW-1:0] n);
    logic [15:0] x;
    logic [12:0] y;
    logic [29:0] prod;
    logic [11:0] q;
    x    = ({5'd0, n} << 4) + ({5'd0, n} << 3) + {5'd0, n} + 16'd12;
    y    = x[15:3];
    prod = {17'd0, y} * 30'd43691;
    q    = prod[28:17];
    return (q > {1'b0, DurMax}) ? DurMax : q[DurW-1:0];
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  assign pop = q_not_empty && (!out_valid || result_out.ready);

  always_comb begin
    logic              cap_e;
    logic              pl_e;
    logic [CountW-1:0] rc_e;
    logic [CountW-1:0] qc_e;
    logic [IndexW-1:0] iif_e;
    capturing_next      = capturing;
    previous_level_next = previous_level;
    run_count_next      = run_count;
    quiet_count_next    = quiet_count;
    items_in_frame_next = items_in_frame;
    halted_next         = halted;
    emit                = 1'b0;
    emit_dur            = regs.tail_value;
    emit_level          = previous_level;
    emit_index          = items_in_frame;
    emit_end            = 1'b0;
    cap_e               = capturing;
    pl_e                = previous_level;
    rc_e                = run_count;
    qc_e                = quiet_count;
    iif_e               = items_in_frame;
    if (pop && !halted) begin
      if (!capturing && q_level) begin
        cap_e = 1'b1;
        pl_e  = 1'b1;
        rc_e  = '0;
        qc_e  = '0;
        iif_e = '0;
      end
      if (cap_e) begin
        capturing_next      = 1'b1;
        items_in_frame_next = iif_e;
        emit_index          = iif_e;
        emit_level          = pl_e;
        if (qc_e > {1'b0, regs.timeout_limit}) begin
          emit                = 1'b1;
          emit_end            = 1'b1;
          emit_dur            = regs.tail_value;
          capturing_next      = 1'b0;
          run_count_next      = '0;
          quiet_count_next    = '0;
          previous_level_next = 1'b1;
        end else begin
          if (q_level != pl_e) begin
            emit     = 1'b1;
            emit_dur = rescale(rc_e);
            rc_e     = '0;
            qc_e     = '0;
          end
          previous_level_next = q_level;
          run_count_next      = sat_inc(rc_e);
          quiet_count_next    = sat_inc(qc_e);
        end
        if (emit) begin
          items_in_frame_next = iif_e + 1'b1;
        end
      end
    end
    emit_ovf = emit && (items_in_frame_next >= regs.max_runs);
    if (emit_ovf) begin
      halted_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing      <= 1'b0;
      previous_level <= 1'b0;
      run_count      <= '0;
      quiet_count    <= '0;
      items_in_frame <= '0;
      halted         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      capturing      <= capturing_next;
      previous_level <= previous_level_next;
      run_count      <= run_count_next;
      quiet_count    <= quiet_count_next;
      items_in_frame <= items_in_frame_next;
      halted         <= halted_next;
      if (pop) begin
        out_valid <= emit;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      result_out.duration  <= emit_dur;
      result_out.run_level <= emit_level;
      result_out.run_index <= emit_index;
      result_out.frame_end <= emit_end;
      result_out.overflow  <= emit_ovf;
    end
  end

  assign result_out.valid = out_valid;

endmodule
`default_nettype wire

### hdl/ir_pulse_width_capture_core.sv
// Top level of the IR pulse-width capture block: front, level queue and back.
//
//  channel     | dir | accept              | payload
//  sample_in   | in  | valid && ready      | sample_byte[7:0]
//  result_out  | out | valid && ready      | duration, run_level, run_index, frame_end, overflow
//  cfg         | in  | valid && ready      | index[1:0], data[10:0]; ready is always high
//
// One sample per cycle while the queue has room; a result is registered as its level is popped.
// The level queue (QueueDepth beats) absorbs stalls of the result channel;
// sample_in.ready drops only when the queue is full.
// rst is synchronous: counters, queue pointers and the result valid flag clear,
// registers return to their reset values.
`default_nettype none
module ir_pulse_width_capture_core #(
  parameter int unsigned QueueDepth = irpwc_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  irpwc_sample_if.sink     sample_in,
  irpwc_result_if.source   result_out,
  irpwc_cfg_if.sink        cfg
);
  import irpwc_pkg::*;

  cfg_t regs;
  logic push;
  logic push_level;
  logic full;
  logic not_empty;
  logic head_level;
  logic pop;

  irpwc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .cfg        (cfg),
    .full       (full),
    .push       (push),
    .push_level (push_level),
    .regs       (regs)
  );

  irpwc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_level (push_level),
    .pop        (pop),
    .full       (full),
    .not_empty  (not_empty),
    .head_level (head_level)
  );

  irpwc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .q_not_empty (not_empty),
    .q_level     (head_level),
    .pop         (pop),
    .result_out  (result_out)
  );

endmodule
`default_nettype wire

### hdl/irpwc_checker.sv
// Port-level checks of the IR pulse-width capture block and their bind.
`default_nettype none
module irpwc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_halt_after_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_overflow |=> !out_valid)
    else $error("result after overflow");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_reset_opens_in: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("sample channel not ready after reset");

endmodule

bind ir_pulse_width_capture_core irpwc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (sample_in.ready),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .out_overflow (result_out.overflow)
);
`default_nettype wire
